// ===== hw/rtl/ntfs_rld_pkg.sv =====
// Shared types and constants for the run list decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ntfs_rld_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int SIZE_W      = 4;
    localparam int POS_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(8);

    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               fresh;
        logic [SIZE_W-1:0]  off_size;
        logic [WORD_W-1:0]  run_length;
        logic [WORD_W-1:0]  offset;
    } t_run_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/ntfs_rld_fifo.sv =====
// Short command queue between the byte parser and the cluster adder.
// Depends on ntfs_rld_pkg for the command type and depth.
`default_nettype none

module ntfs_rld_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  ntfs_rld_pkg::t_run_cmd  i_wdata,
    output logic                    o_full,
    input  wire                     i_pop,
    output ntfs_rld_pkg::t_run_cmd  o_rdata,
    output logic                    o_empty
);
    import ntfs_rld_pkg::*;

    t_run_cmd            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = do_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== hw/rtl/ntfs_rld_front.sv =====
// Byte parser: walks headers, length and offset bytes, emits run, end and error commands.
// Depends on ntfs_rld_pkg for the command type and size limits.
`default_nettype none

module ntfs_rld_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_accept,
    input  wire  [ntfs_rld_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire                                   i_list_start,
    output logic                                  o_enq,
    output ntfs_rld_pkg::t_run_cmd                o_cmd
);
    import ntfs_rld_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_OFFSET = 4'b1000
    } t_phase;

    function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] acc,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] res;
        res = acc;
        for (int k = 0; k < WORD_W / BYTE_W; k++) begin
            if (pos == POS_W'(k)) begin
                res[k*BYTE_W +: BYTE_W] = b;
            end
        end
        return res;
    endfunction

    t_phase              r_phase, n_phase, eff_phase;
    logic [SIZE_W-1:0]   r_len_left, n_len_left;
    logic [SIZE_W-1:0]   r_off_size, n_off_size;
    logic [SIZE_W-1:0]   r_off_left, n_off_left;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [WORD_W-1:0]   r_len_acc, n_len_acc;
    logic [WORD_W-1:0]   r_off_acc, n_off_acc;
    logic                r_fresh, n_fresh, fresh_in;
    logic [SIZE_W-1:0]   lsz, osz;
    logic [WORD_W-1:0]   len_ins, off_ins;

    assign lsz       = i_data_byte[SIZE_W-1:0];
    assign osz       = i_data_byte[BYTE_W-1:SIZE_W];
    assign eff_phase = i_list_start ? PH_HEADER : r_phase;
    assign fresh_in  = r_fresh || i_list_start;
    assign len_ins   = put_byte(r_len_acc, r_pos, i_data_byte);
    assign off_ins   = put_byte(r_off_acc, r_pos, i_data_byte);

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_off_size = r_off_size;
        n_off_left = r_off_left;
        n_pos      = r_pos;
        n_len_acc  = r_len_acc;
        n_off_acc  = r_off_acc;
        n_fresh    = r_fresh;
        o_enq      = 1'b0;
        o_cmd      = '0;
        o_cmd.fresh = fresh_in;
        if (i_accept) begin
            case (eff_phase)
                PH_HEADER: begin
                    if (i_data_byte == '0) begin
                        o_enq      = 1'b1;
                        o_cmd.kind = KIND_END;
                        n_phase    = PH_IDLE;
                    end else if (lsz > SIZE_MAX || osz > SIZE_MAX) begin
                        o_enq      = 1'b1;
                        o_cmd.kind = KIND_ERROR;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_len_left = lsz;
                        n_off_size = osz;
                        n_off_left = osz;
                        n_pos      = '0;
                        n_len_acc  = '0;
                        n_off_acc  = '0;
                        n_phase    = (lsz != '0) ? PH_LENGTH : PH_OFFSET;
                    end
                end
                PH_LENGTH: begin
                    n_len_acc  = len_ins;
                    n_pos      = r_pos + POS_W'(1);
                    n_len_left = r_len_left - SIZE_W'(1);
                    if (n_len_left == '0) begin
                        n_pos = '0;
                        if (r_off_left == '0) begin
                            o_enq            = 1'b1;
                            o_cmd.kind       = KIND_RUN;
                            o_cmd.run_length = len_ins;
                            o_cmd.offset     = r_off_acc;
                            o_cmd.off_size   = r_off_size;
                            n_phase          = PH_HEADER;
                        end else begin
                            n_phase = PH_OFFSET;
                        end
                    end
                end
                PH_OFFSET: begin
                    n_off_acc  = off_ins;
                    n_pos      = r_pos + POS_W'(1);
                    n_off_left = r_off_left - SIZE_W'(1);
                    if (n_off_left == '0) begin
                        n_pos            = '0;
                        o_enq            = 1'b1;
                        o_cmd.kind       = KIND_RUN;
                        o_cmd.run_length = r_len_acc;
                        o_cmd.offset     = off_ins;
                        o_cmd.off_size   = r_off_size;
                        n_phase          = PH_HEADER;
                    end
                end
                default: begin
                end
            endcase
            n_fresh = o_enq ? 1'b0 : fresh_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_len_left <= '0;
            r_off_size <= '0;
            r_off_left <= '0;
            r_pos      <= '0;
            r_fresh    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_size <= n_off_size;
            r_off_left <= n_off_left;
            r_pos      <= n_pos;
            r_fresh    <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_acc <= n_len_acc;
        r_off_acc <= n_off_acc;
    end

    a_len_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LENGTH |-> r_len_left != '0)
        else $error("length phase with no bytes left");

    a_off_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_OFFSET |-> r_off_left != '0 && r_off_left == r_off_size - r_pos)
        else $error("offset phase out of step");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_enq && o_cmd.kind == KIND_RUN |-> o_cmd.off_size <= SIZE_MAX)
        else $error("run command with oversize offset");

endmodule

`default_nettype wire

// ===== hw/rtl/ntfs_rld_back.sv =====
// Cluster adder: sign-extends each offset, adds it to the running cluster.
// Depends on ntfs_rld_pkg for the command type; holds the result register.
`default_nettype none

module ntfs_rld_back (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_q_empty,
    input  ntfs_rld_pkg::t_run_cmd                i_cmd,
    output logic                                  o_take,
    input  wire                                   i_pop,
    output logic                                  o_empty,
    output ntfs_rld_pkg::t_kind                   o_kind,
    output logic        [ntfs_rld_pkg::WORD_W-1:0] o_run_length,
    output logic signed [ntfs_rld_pkg::WORD_W-1:0] o_start_cluster
);
    import ntfs_rld_pkg::*;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [WORD_W-1:0]   r_len;
    logic [WORD_W-1:0]   r_start;
    logic [WORD_W-1:0]   r_prev, n_prev;
    logic [WORD_W-1:0]   base, ext, mask, sum;

    assign o_take = !i_q_empty && (!r_out_valid || i_pop);

    always_comb begin
        ext  = '0;
        mask = '0;
        for (int k = 1; k <= WORD_W / BYTE_W; k++) begin
            if (i_cmd.off_size == SIZE_W'(k)) begin
                mask = (WORD_W'(1) << (k * BYTE_W)) - WORD_W'(1);
                if (k == WORD_W / BYTE_W) begin
                    ext = i_cmd.offset;
                end else if (i_cmd.offset[k*BYTE_W-1]) begin
                    ext = i_cmd.offset | ~mask;
                end else begin
                    ext = i_cmd.offset & mask;
                end
            end
        end
        base = i_cmd.fresh ? '0 : r_prev;
        sum  = base + ext;
        n_prev = (i_cmd.kind == KIND_RUN) ? sum : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_prev;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind <= i_cmd.kind;
            if (i_cmd.kind == KIND_RUN) begin
                r_len   <= i_cmd.run_length;
                r_start <= sum;
            end else begin
                r_len   <= '0;
                r_start <= '0;
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_kind          = r_kind;
    assign o_run_length    = r_len;
    assign o_start_cluster = r_start;

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != KIND_RUN |-> r_len == '0 && r_start == '0)
        else $error("end or error record with nonzero payload");

    a_run_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_take) && $past(i_cmd.kind) == KIND_RUN
        |-> r_start == r_prev)
        else $error("running cluster out of step with result");

endmodule

`default_nettype wire

// ===== hw/rtl/ntfs_runlist_decoder.sv =====
// Top level of the run list decoder: byte parser, command queue, cluster adder.
// Depends on ntfs_rld_pkg, ntfs_rld_front, ntfs_rld_fifo and ntfs_rld_back.
//
//   side     handshake        payload
//   input    push / full      i_data_byte, i_list_start
//   result   empty / pop      o_record_kind, o_run_length, o_start_cluster
//
// One byte is taken per cycle while full is low; a result passes through the
// command queue and then the result register before it reaches the ports.
// The parser handles one byte per cycle; full holds it off while results are not popped.
// full rises when the two-entry command queue holds two commands.
// Reset is synchronous on i_rst_n and needs no clearing pass.
`default_nettype none

module ntfs_runlist_decoder (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    push,
    output logic                                   full,
    input  wire  [ntfs_rld_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire                                    i_list_start,
    output logic                                   empty,
    input  wire                                    pop,
    output logic        [1:0]                      o_record_kind,
    output logic        [ntfs_rld_pkg::WORD_W-1:0] o_run_length,
    output logic signed [ntfs_rld_pkg::WORD_W-1:0] o_start_cluster
);
    import ntfs_rld_pkg::*;

    logic      accept;
    logic      enq;
    t_run_cmd  front_cmd;
    t_run_cmd  q_cmd;
    logic      q_empty;
    logic      take;
    t_kind     kind;

    assign accept        = push && !full;
    assign o_record_kind = kind;

    ntfs_rld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_list_start (i_list_start),
        .o_enq        (enq),
        .o_cmd        (front_cmd)
    );

    ntfs_rld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_pop   (take),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    ntfs_rld_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (q_cmd),
        .o_take          (take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (kind),
        .o_run_length    (o_run_length),
        .o_start_cluster (o_start_cluster)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for ntfs_runlist_decoder: drives run list bytes, predicts and checks each decoded record.
// Depends on ntfs_rld_pkg and the ntfs_runlist_decoder RTL; self-checking, no files read.
module tb_top;
    import ntfs_rld_pkg::*;

    localparam int MAX_GAP     = 18;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_OFFSET = 2'd3
    } t_phase;

    typedef struct {
        t_kind              kind;
        logic [WORD_W-1:0]  length;
        logic [WORD_W-1:0]  cluster;
    } t_run_rec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                i_list_start = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [1:0]          o_record_kind;
    logic [WORD_W-1:0]   o_run_length;
    logic signed [WORD_W-1:0] o_start_cluster;

    t_run_rec            pending_runs[$];
    int unsigned         mismatches = 0;
    int unsigned         stall_cycles = 0;
    int unsigned         bytes_used = 0;
    bit                  idle_on = 1'b1;

    t_phase              dec_phase = PH_IDLE;
    logic [SIZE_W-1:0]   len_left = '0;
    logic [SIZE_W-1:0]   off_size = '0;
    logic [SIZE_W-1:0]   off_left = '0;
    logic [POS_W-1:0]    byte_pos = '0;
    logic [WORD_W-1:0]   len_acc = '0;
    logic [WORD_W-1:0]   off_acc = '0;
    logic [WORD_W-1:0]   prev_cluster = '0;

    ntfs_runlist_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_list_start    (i_list_start),
        .empty           (empty),
        .pop             (pop),
        .o_record_kind   (o_record_kind),
        .o_run_length    (o_run_length),
        .o_start_cluster (o_start_cluster)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] sign_extend_offset(
        input logic [WORD_W-1:0] v, input logic [SIZE_W-1:0] size);
        logic [WORD_W-1:0] mask;
        int unsigned       bits;
        if (size == 0 || size >= SIZE_MAX) begin
            return v;
        end
        bits = 8 * size;
        mask = (64'd1 << bits) - 64'd1;
        v = v & mask;
        if (v[bits-1]) begin
            v = v | ~mask;
        end
        return v;
    endfunction

    task automatic close_run();
        logic [WORD_W-1:0] start;
        start = prev_cluster;
        if (off_size != 0) begin
            start = prev_cluster + sign_extend_offset(off_acc, off_size);
        end
        prev_cluster = start;
        dec_phase = PH_HEADER;
        pending_runs.push_back('{KIND_RUN, len_acc, start});
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start);
        logic [SIZE_W-1:0] lsz;
        logic [SIZE_W-1:0] osz;
        if (start) begin
            prev_cluster = '0;
            dec_phase = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER: begin
                lsz = b[3:0];
                osz = b[7:4];
                if (b == '0) begin
                    dec_phase = PH_IDLE;
                    pending_runs.push_back('{KIND_END, '0, '0});
                end else if (lsz > SIZE_MAX || osz > SIZE_MAX) begin
                    dec_phase = PH_IDLE;
                    pending_runs.push_back('{KIND_ERROR, '0, '0});
                end else begin
                    len_left = lsz;
                    off_size = osz;
                    off_left = osz;
                    byte_pos = '0;
                    len_acc = '0;
                    off_acc = '0;
                    dec_phase = (lsz != 0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                len_acc = len_acc | (WORD_W'(b) << (8 * byte_pos));
                byte_pos = byte_pos + 1'b1;
                len_left = len_left - 1'b1;
                if (len_left == 0) begin
                    byte_pos = '0;
                    if (off_left == 0) begin
                        close_run();
                    end else begin
                        dec_phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                off_acc = off_acc | (WORD_W'(b) << (8 * byte_pos));
                byte_pos = byte_pos + 1'b1;
                off_left = off_left - 1'b1;
                if (off_left == 0) begin
                    byte_pos = '0;
                    close_run();
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push = 1'b1;
        i_data_byte = b;
        i_list_start = start;
        do @(posedge i_clk); while (full);
        if (start || dec_phase != PH_IDLE) begin
            bytes_used++;
        end
        decode_byte(b, start);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_runs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return SIZE_W'($urandom_range(0, 3));
            6, 7, 8: return SIZE_W'($urandom_range(0, 8));
            default: return SIZE_MAX;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] bad_header();
        logic [SIZE_W-1:0] big;
        logic [SIZE_W-1:0] any_size;
        big = SIZE_W'($urandom_range(9, 15));
        any_size = SIZE_W'($urandom);
        return $urandom_range(0, 1) ? {big, any_size} : {any_size, big};
    endfunction

    task automatic send_run(input logic start, input int unsigned keep);
        logic [SIZE_W-1:0] lsz;
        logic [SIZE_W-1:0] osz;
        int unsigned       total;
        lsz = rand_size();
        osz = rand_size();
        if (lsz == 0 && osz == 0) begin
            lsz = SIZE_W'(1);
        end
        send_byte({osz, lsz}, start);
        total = int'(lsz) + int'(osz);
        if (keep < total) begin
            total = keep;
        end
        repeat (total) begin
            send_byte(rand_byte(), 1'b0);
        end
    endtask

    task automatic send_list();
        int unsigned runs;
        runs = $urandom_range(1, 6);
        send_run(1'b1, 16);
        repeat (runs - 1) begin
            send_run(1'b0, 16);
        end
        case ($urandom_range(0, 9))
            8: send_byte(bad_header(), 1'b0);
            9: begin
            end
            default: send_byte(8'h00, 1'b0);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            send_byte(rand_byte(), 1'b0);
        end
    endtask

    task automatic test_directed();
        send_byte(8'h31, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (7) begin
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'h7F, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h90, 1'b1);
        wait_drained();
    endtask

    task automatic test_well_formed_lists(input int unsigned n_bytes);
        int unsigned goal;
        goal = bytes_used + n_bytes;
        while (bytes_used < goal) begin
            send_list();
        end
        wait_drained();
    endtask

    task automatic test_back_to_back(input int unsigned n_bytes);
        int unsigned goal;
        goal = bytes_used + n_bytes;
        idle_on = 1'b0;
        while (bytes_used < goal) begin
            send_list();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause(input int unsigned n_bytes);
        int unsigned goal;
        goal = bytes_used + n_bytes;
        while (bytes_used < goal) begin
            send_list();
            wait_drained();
        end
    endtask

    task automatic test_noise(input int unsigned n_bytes);
        int unsigned goal;
        goal = bytes_used + n_bytes;
        while (bytes_used < goal) begin
            case ($urandom_range(0, 3))
                0: send_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
                1: send_run(1'b1, $urandom_range(0, 8));
                2: send_byte(bad_header(), 1'($urandom_range(0, 1)));
                default: send_list();
            endcase
        end
        wait_drained();
    endtask

    initial begin
        @(negedge i_clk);
        wait (i_rst_n);
        forever begin
            repeat (idle_on ? $urandom_range(0, MAX_GAP) : 0) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_run_rec want;
        if (i_rst_n && pop && !empty) begin
            if (pending_runs.size() == 0) begin
                flag_mismatch("transaction with none pending, run_length", '0, o_run_length);
            end else begin
                want = pending_runs.pop_front();
                if (o_record_kind != want.kind) begin
                    flag_mismatch("record_kind", WORD_W'(want.kind), WORD_W'(o_record_kind));
                end
                if (o_run_length != want.length) begin
                    flag_mismatch("run_length", want.length, o_run_length);
                end
                if (o_start_cluster != want.cluster) begin
                    flag_mismatch("start_cluster", want.cluster, o_start_cluster);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_well_formed_lists(900);
        test_back_to_back(250);
        test_drain_pause(150);
        test_noise(350);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_runs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
